FILE: src/plk_pkg.sv
// Shared types and codes for the positional list engine.
// No dependencies; imported by plk_cmp, positional_list_engine and the testbench.
package plk_pkg;

  // Request operation codes (carried on in_tuser).
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_MIN    = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_POS   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Field widths of the stream words.
  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 7;
  localparam int unsigned ValW    = 32;
  localparam int unsigned MinPosW = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // Result of the shared comparator.
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

FILE: src/plk_ram.sv
// Entry storage: one write port and one registered read port.
// Depends on nothing but its parameters.
module plk_ram #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/plk_cmp.sv
// Shared signed comparator used by search and minimum scans.
// Depends on plk_pkg for the result struct.
module plk_cmp #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output plk_pkg::cmp_res_t     res
);
  import plk_pkg::*;

  always_comb begin
    res.eq = (a == b);
    res.lt = ($signed(a) < $signed(b));
  end

endmodule

FILE: src/positional_list_engine.sv
// Positional list engine: ordered list of up to DEPTH signed entries in one RAM.
// Requests are taken one at a time: in_tready is high only in IDLE, so a new word
// is accepted only after the previous result is loaded. Insert moves entries up
// from the tail, remove and read scan from the position, search and minimum scan
// the whole list; errors and unused ops answer directly. A held result word stalls.
// Reset (rst_n low, synchronous) empties the list; RAM is not cleared. Uses plk_pkg.
module positional_list_engine #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [6:0] position, [38:7] value, [39] zero
  input  logic [plk_pkg::InDataW-1:0]    in_tdata,
  // [2:0] op
  input  logic [plk_pkg::OpW-1:0]        in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] data_out, [37:32] min_position, [38] found,
  // [45:39] entry_count, [47:46] status
  output logic [plk_pkg::OutDataW-1:0]   out_tdata
);
  import plk_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > PosW) ? CW : PosW;

  // IDLE takes a word, INS walks down moving entries up, SCAN walks up
  // (remove, read, search, minimum), DONE waits for the result register.
  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;      // next RAM address to walk
  logic [CW-1:0]         lim_r, lim_nxt;      // scan stops before this index
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [OpW-1:0]        op_r, op_nxt;
  logic                  pend_r, pend_nxt;    // RAM read data valid this cycle
  logic [AW-1:0]         pend_idx_r, pend_idx_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [DATA_WIDTH-1:0] best_r, best_nxt;
  logic [AW-1:0]         minpos_r, minpos_nxt;
  logic                  found_r, found_nxt;
  status_t               status_r, status_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OutDataW-1:0]   out_tdata_r, out_tdata_nxt;

  // RAM and comparator hookup
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] cmp_b;
  cmp_res_t              cmp_res;

  // Input word fields
  logic [PosW-1:0]         pos_in;
  logic [ValW-1:0]         val_raw;
  logic [PW-1:0]           pos_in_ext;
  logic [PW-1:0]           count_ext;
  logic [DATA_WIDTH+ValW-1:0] val_sext;
  logic [CW-1:0]           idx_dec;

  // Result field widening
  logic [DATA_WIDTH+ValW-1:0] data_zext;
  logic [CW+CountW-1:0]       cnt_zext;
  logic [AW+MinPosW-1:0]      minpos_zext;

  assign pos_in     = in_tdata[PosW-1:0];
  assign val_raw    = in_tdata[PosW+ValW-1:PosW];
  assign pos_in_ext = PW'(pos_in);
  assign count_ext  = PW'(count_r);
  assign val_sext   = {{DATA_WIDTH{val_raw[ValW-1]}}, val_raw};
  assign idx_dec    = idx_r - 1'b1;

  assign data_zext   = {{ValW{1'b0}}, data_r};
  assign cnt_zext    = {{CountW{1'b0}}, count_r};
  assign minpos_zext = {{MinPosW{1'b0}}, minpos_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Minimum compares against the running best, search against the key.
  assign cmp_b = (op_r == OP_MIN) ? best_r : val_r;

  plk_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  plk_cmp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cmp (
    .a   (rdata),
    .b   (cmp_b),
    .res (cmp_res)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    lim_nxt        = lim_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    op_nxt         = op_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    data_nxt       = data_r;
    best_nxt       = best_r;
    minpos_nxt     = minpos_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    we             = 1'b0;
    waddr          = pend_idx_r;
    wdata          = rdata;
    raddr          = idx_r[AW-1:0];

    // Drop the result once the sink takes it.
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          pos_nxt    = pos_in_ext;
          val_nxt    = val_sext[DATA_WIDTH-1:0];
          op_nxt     = in_tuser;
          data_nxt   = '0;
          best_nxt   = '0;
          minpos_nxt = '0;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_tuser)
            OP_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else if (pos_in_ext > count_ext) begin
                status_nxt = ST_POS;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_INS;
              end
            end
            OP_REMOVE, OP_READ: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (pos_in_ext >= count_ext) begin
                status_nxt = ST_POS;
              end else begin
                idx_nxt   = CW'(pos_in_ext);
                lim_nxt   = (in_tuser == OP_READ) ? CW'(pos_in_ext + 1'b1) : count_r;
                state_nxt = S_SCAN;
              end
            end
            OP_SEARCH: begin
              idx_nxt   = '0;
              lim_nxt   = count_r;
              state_nxt = S_SCAN;
            end
            OP_MIN: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                lim_nxt   = count_r;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // unused codes answer ok with zero data
            end
          endcase
        end
      end

      S_INS: begin
        // pend_idx_r is the destination of the word now on rdata.
        raddr = idx_dec[AW-1:0];
        if (pend_r) begin
          we = 1'b1;
        end else if (PW'(idx_r) == pos_r) begin
          we        = 1'b1;
          waddr     = pos_r[AW-1:0];
          wdata     = val_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_DONE;
        end
        if (PW'(idx_r) > pos_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_dec;
        end
      end

      S_SCAN: begin
        // pend_idx_r is the source address of the word now on rdata.
        if (idx_r != lim_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_r + 1'b1;
        end
        if (pend_r) begin
          case (op_r)
            OP_REMOVE: begin
              if (pend_idx_r == pos_r[AW-1:0]) begin
                data_nxt = rdata;
              end else begin
                we    = 1'b1;
                waddr = pend_idx_r - 1'b1;
              end
            end
            OP_READ: begin
              data_nxt = rdata;
            end
            OP_SEARCH: begin
              if (cmp_res.eq) begin
                found_nxt = 1'b1;
              end
            end
            OP_MIN: begin
              if (pend_idx_r == '0 || cmp_res.lt) begin
                best_nxt   = rdata;
                minpos_nxt = pend_idx_r;
              end
            end
            default: begin
            end
          endcase
        end else if (idx_r == lim_r) begin
          if (op_r == OP_REMOVE) begin
            count_nxt = count_r - 1'b1;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Load the result register as soon as it is free.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {status_r, cnt_zext[CountW-1:0], found_r,
                            minpos_zext[MinPosW-1:0], data_zext[ValW-1:0]};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    idx_r       <= idx_nxt;
    lim_r       <= lim_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    op_r        <= op_nxt;
    pend_idx_r  <= pend_idx_nxt;
    data_r      <= data_nxt;
    best_r      <= best_nxt;
    minpos_r    <= minpos_nxt;
    found_r     <= found_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // The list never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // Count moves by at most one per request.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
               count_r == $past(count_r) - 1'b1))
    else $error("entry count jumped");

  // RAM is written only while walking the list.
  a_we_walk: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_INS || state_r == S_SCAN))
    else $error("RAM write outside a walk");

  // An accepted word always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted word dropped");

endmodule

FILE: verif/positional_list_engine_tb.sv
// Self-checking testbench for positional_list_engine: directed table, then random traffic.
// Uses plk_pkg for op and status codes and for the stream word widths.
// Results are checked field by field against a queue-based list predictor, or against a directed row's typed result.
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plk_pkg::*;

  localparam int Depth = 64;

  // Op codes the block decodes as no-ops; they still return one result.
  localparam logic [OpW-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE7 = 3'd7;

  // Result word, laid out exactly as out_tdata (status in the top bits).
  typedef struct packed {
    logic [1:0]         status;
    logic [CountW-1:0]  count;
    logic               found;
    logic [MinPosW-1:0] minpos;
    logic [ValW-1:0]    data;
  } list_result_t;

  // One row of the directed plan; res is used only where typed is set.
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    logic            typed;
    list_result_t    res;
  } plan_row_t;

  localparam list_result_t NO_RES = '0;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic [OpW-1:0]      in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  // Predictor state: the list contents, position 0 first.
  int           list_vals[$];
  // Results owed by the block, in request order.
  list_result_t pending_results[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  // Long receiver hold-off: main code bumps hold_epoch, the receiver counts.
  int hold_epoch = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  // Directed plan: empty-list errors, position errors, extremes of the value,
  // a tie for the minimum, and the unused op codes.
  plan_row_t plan_rows [24] = '{
    '{OP_READ,   7'd0,   32'd0,          1'b1, '{ST_EMPTY, 7'd0, 1'b0, 6'd0, 32'd0}},
    '{OP_REMOVE, 7'd0,   32'd0,          1'b1, '{ST_EMPTY, 7'd0, 1'b0, 6'd0, 32'd0}},
    '{OP_MIN,    7'd0,   32'd0,          1'b1, '{ST_EMPTY, 7'd0, 1'b0, 6'd0, 32'd0}},
    '{OP_SEARCH, 7'd0,   32'd5,          1'b1, '{ST_OK,    7'd0, 1'b0, 6'd0, 32'd0}},
    '{OP_SPARE5, 7'd0,   32'd0,          1'b1, '{ST_OK,    7'd0, 1'b0, 6'd0, 32'd0}},
    '{OP_INSERT, 7'd1,   32'd7,          1'b1, '{ST_POS,   7'd0, 1'b0, 6'd0, 32'd0}},
    '{OP_INSERT, 7'd0,   32'h7FFF_FFFF,  1'b1, '{ST_OK,    7'd1, 1'b0, 6'd0, 32'd0}},
    '{OP_INSERT, 7'd0,   32'h8000_0000,  1'b1, '{ST_OK,    7'd2, 1'b0, 6'd0, 32'd0}},
    '{OP_INSERT, 7'd2,   32'hFFFF_FFFF,  1'b0, NO_RES},
    '{OP_READ,   7'd0,   32'd0,          1'b1,
      '{ST_OK, 7'd3, 1'b0, 6'd0, 32'h8000_0000}},
    '{OP_READ,   7'd3,   32'd0,          1'b1, '{ST_POS,   7'd3, 1'b0, 6'd0, 32'd0}},
    '{OP_REMOVE, 7'd127, 32'd0,          1'b1, '{ST_POS,   7'd3, 1'b0, 6'd0, 32'd0}},
    '{OP_SEARCH, 7'd0,   32'h7FFF_FFFF,  1'b0, NO_RES},
    '{OP_SEARCH, 7'd0,   32'd0,          1'b0, NO_RES},
    '{OP_MIN,    7'd0,   32'd0,          1'b0, NO_RES},
    '{OP_INSERT, 7'd3,   32'h8000_0000,  1'b0, NO_RES},
    '{OP_MIN,    7'd0,   32'd0,          1'b0, NO_RES},
    '{OP_INSERT, 7'd127, 32'd0,          1'b1, '{ST_POS,   7'd4, 1'b0, 6'd0, 32'd0}},
    '{OP_SPARE6, 7'd0,   32'd0,          1'b1, '{ST_OK,    7'd4, 1'b0, 6'd0, 32'd0}},
    '{OP_SPARE7, 7'd127, 32'hFFFF_FFFF,  1'b1, '{ST_OK,    7'd4, 1'b0, 6'd0, 32'd0}},
    '{OP_REMOVE, 7'd0,   32'd0,          1'b0, NO_RES},
    '{OP_REMOVE, 7'd3,   32'd0,          1'b1, '{ST_POS,   7'd3, 1'b0, 6'd0, 32'd0}},
    '{OP_READ,   7'd2,   32'd0,          1'b0, NO_RES},
    '{OP_READ,   7'd64,  32'd0,          1'b1, '{ST_POS,   7'd3, 1'b0, 6'd0, 32'd0}}
  };

  positional_list_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Apply one request to the list and return the result the block owes.
  // A failed request leaves the list alone; error results carry zero data.
  function automatic list_result_t apply_request(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                                                 logic [ValW-1:0] val);
    list_result_t r;
    int           p;
    int           best;
    r = '0;
    p = int'(pos);
    case (op)
      OP_INSERT: begin
        if (list_vals.size() >= Depth) r.status = ST_FULL;
        else if (p > list_vals.size()) r.status = ST_POS;
        else list_vals.insert(p, int'(val));
      end
      OP_REMOVE, OP_READ: begin
        if (list_vals.size() == 0) r.status = ST_EMPTY;
        else if (p >= list_vals.size()) r.status = ST_POS;
        else begin
          r.data = list_vals[p];
          if (op == OP_REMOVE) list_vals.delete(p);
        end
      end
      OP_SEARCH: begin
        foreach (list_vals[i])
          if (list_vals[i] == int'(val)) r.found = 1'b1;
      end
      OP_MIN: begin
        if (list_vals.size() == 0) r.status = ST_EMPTY;
        else begin
          // Strict compare: the first of several equal minima wins.
          best = 0;
          for (int i = 1; i < list_vals.size(); i++)
            if (list_vals[i] < list_vals[best]) best = i;
          r.minpos = best[MinPosW-1:0];
        end
      end
      default: ;
    endcase
    r.count = CountW'(list_vals.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatch_count < 40)
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one request word after a random idle gap; hold it until accepted,
  // then record what the block must return for it.
  task automatic send_request(logic [OpW-1:0] op, logic [PosW-1:0] pos, logic [ValW-1:0] val,
                              logic typed, list_result_t typed_res);
    list_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, val, pos};
    do @(posedge clk); while (!in_tready);
    // The predictor always runs so its list stays in step with the block.
    predicted = apply_request(op, pos, val);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Result side: check each accepted word, then decide ready for the next edge.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", got, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data)     report_mismatch("data_out", got.data, want.data);
        if (got.minpos !== want.minpos) report_mismatch("min_position", got.minpos, want.minpos);
        if (got.found !== want.found)   report_mismatch("found", got.found, want.found);
        if (got.count !== want.count)   report_mismatch("entry_count", got.count, want.count);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
    end
    // Start a long hold-off when asked, so the block backs up into its input.
    if (hold_epoch != hold_seen) begin
      hold_seen = hold_epoch;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stimulus.
  initial begin
    int              n_size;
    int              pick;
    bit              filling;
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;

    // Hold reset low at the start, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan, back to back.
    foreach (plan_rows[i])
      send_request(plan_rows[i].op, plan_rows[i].pos, plan_rows[i].val,
                   plan_rows[i].typed, plan_rows[i].res);

    // Random part: four idling phases of 500 words each. Within a phase,
    // stretches of 120 words alternate between filling the list (to reach
    // the full case) and draining it (to reach the empty cases).
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      // Back-pressure test: receiver holds off while the sender keeps offering.
      if (phase == 2) hold_epoch++;

      for (int k = 0; k < 500; k++) begin
        filling = ((k / 120) % 2) == 0;
        n_size  = list_vals.size();

        // Pick the op; the weights lean toward insert or remove.
        pick = $urandom_range(99);
        if (pick < (filling ? 70 : 10))      op = OP_INSERT;
        else if (pick < 75)                  op = OP_REMOVE;
        else if (pick < 82)                  op = OP_READ;
        else if (pick < 90)                  op = OP_SEARCH;
        else if (pick < 97)                  op = OP_MIN;
        else                                 op = OpW'($urandom_range(7, 5));

        // Mostly a legal position; now and then any 7-bit value.
        if ($urandom_range(99) < 85) begin
          if (op == OP_INSERT) pos = PosW'($urandom_range(n_size, 0));
          else if (n_size > 0) pos = PosW'($urandom_range(n_size - 1, 0));
          else pos = '0;
        end else begin
          pos = PosW'($urandom_range(127, 0));
        end

        // Values: hits for search, extremes, a small range for ties, or anything.
        pick = $urandom_range(99);
        if (op == OP_SEARCH && n_size > 0 && pick < 50) begin
          val = list_vals[$urandom_range(n_size - 1, 0)];
        end else if (pick < 60) begin
          case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'h0000_0000;
            default: val = 32'hFFFF_FFFF;
          endcase
        end else if (pick < 80) begin
          val = ValW'($urandom_range(15, 0)) - 32'd8;
        end else begin
          val = $urandom;
        end

        send_request(op, pos, val, 1'b0, NO_RES);
      end
    end

    in_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (Depth + 8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", pending_results.size(), 0);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/plk_pkg.sv
src/plk_ram.sv
src/plk_cmp.sv
src/positional_list_engine.sv
verif/positional_list_engine_tb.sv
